// ===== rtl/dbslc_pkg.sv =====
// Package for the deadband step level controller.
// Holds the item structs, register index codes and the saturation limits.
// It depends on nothing else.
package dbslc_pkg;

  // Field widths
  localparam int DevW    = 16;
  localparam int LevelW  = 16;
  localparam int PeriodW = 16;
  localparam int DbW     = 15;
  localparam int IntegW  = 40;
  localparam int TrigW   = 39;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 39;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEADBAND    = 3'd0,
    REG_UP_STEP     = 3'd1,
    REG_DOWN_STEP   = 3'd2,
    REG_UP_PERIOD   = 3'd3,
    REG_DOWN_PERIOD = 3'd4,
    REG_MAX_LEVEL   = 3'd5,
    REG_MIN_LEVEL   = 3'd6,
    REG_TRIGGER     = 3'd7
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [PeriodW-1:0]       PeriodRst   = 16'd1;
  localparam logic signed [LevelW-1:0] MaxLevelRst = 16'sh7FFF;
  localparam logic signed [LevelW-1:0] MinLevelRst = 16'sh8000;

  // Saturation limits of the integrator
  localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
  localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

  // One input item: a tick
  typedef struct packed {
    logic signed [DevW-1:0] freq_dev;
    logic                   enable;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic signed [LevelW-1:0] level;
    logic                     updated;
  } out_item_t;

  // A zero period acts as one tick
  function automatic logic [PeriodW-1:0] eff_period(input logic [PeriodW-1:0] p);
    eff_period = (p == '0) ? PeriodW'(1) : p;
  endfunction

endpackage

// ===== rtl/deadband_step_level_controller_unit.sv =====
// Top level of the deadband step level controller: input register, single-pass
// update logic and result register. Depends on dbslc_pkg.
// The accepted item is held in the input register and its result is registered in the result
// register. Throughput: one item per cycle; the input stalls only while both registers are
// full and the result is stalled.
// Reset (rst_n low, synchronous): pipeline empty, state zero, registers at reset values.
module deadband_step_level_controller_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dbslc_pkg::in_item_t               in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output dbslc_pkg::out_item_t              out_data,
  // configuration port
  input  logic                              cfg_we,
  input  logic [dbslc_pkg::CfgIdxW-1:0]     cfg_idx,
  input  logic [dbslc_pkg::CfgDataW-1:0]    cfg_wdata
);

  // Configuration registers
  logic [dbslc_pkg::DbW-1:0]            deadband_r;
  logic signed [dbslc_pkg::LevelW-1:0]  up_step_r;
  logic signed [dbslc_pkg::LevelW-1:0]  down_step_r;
  logic [dbslc_pkg::PeriodW-1:0]        up_period_r;
  logic [dbslc_pkg::PeriodW-1:0]        down_period_r;
  logic signed [dbslc_pkg::LevelW-1:0]  max_level_r;
  logic signed [dbslc_pkg::LevelW-1:0]  min_level_r;
  logic [dbslc_pkg::TrigW-1:0]          trigger_r;

  // Controller state
  logic signed [dbslc_pkg::LevelW-1:0]  level_r, level_nxt;
  logic signed [dbslc_pkg::IntegW-1:0]  integ_r, integ_nxt;
  logic [dbslc_pkg::PeriodW-1:0]        ticks_r, ticks_nxt;
  logic                                 use_down_r, use_down_nxt;
  logic                                 was_en_r, was_en_nxt;
  logic                                 updated_nxt;

  // Pipeline registers
  logic                                 s1_valid_r;
  dbslc_pkg::in_item_t                  s1_item_r;
  logic                                 out_valid_r;
  dbslc_pkg::out_item_t                 out_item_r;
  logic                                 s1_adv;

  // Update datapath
  logic [dbslc_pkg::PeriodW-1:0]        cur_period;
  logic signed [32:0]                   prod;
  logic signed [dbslc_pkg::IntegW:0]    sum;
  logic signed [dbslc_pkg::IntegW-1:0]  sum_sat;
  logic signed [dbslc_pkg::IntegW:0]    sat_ext;
  logic signed [dbslc_pkg::IntegW:0]    trig_pos;
  logic signed [dbslc_pkg::IntegW:0]    trig_neg;
  logic signed [dbslc_pkg::DevW:0]      dev_ext;
  logic signed [dbslc_pkg::DevW:0]      db_pos;
  logic signed [dbslc_pkg::DevW:0]      db_neg;
  logic                                 dev_up, dev_down, take_up, take_down;
  logic signed [dbslc_pkg::LevelW:0]    stepped;
  logic signed [dbslc_pkg::LevelW-1:0]  lo, hi;
  logic signed [dbslc_pkg::LevelW-1:0]  clamped;
  logic [dbslc_pkg::PeriodW-1:0]        new_period;

  // Handshake: stage 1 moves on when the result register is free or drains
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r    <= '0;
      up_step_r     <= '0;
      down_step_r   <= '0;
      up_period_r   <= dbslc_pkg::PeriodRst;
      down_period_r <= dbslc_pkg::PeriodRst;
      max_level_r   <= dbslc_pkg::MaxLevelRst;
      min_level_r   <= dbslc_pkg::MinLevelRst;
      trigger_r     <= '0;
    end else if (cfg_we) begin
      unique case (dbslc_pkg::cfg_reg_t'(cfg_idx))
        dbslc_pkg::REG_DEADBAND:    deadband_r    <= cfg_wdata[dbslc_pkg::DbW-1:0];
        dbslc_pkg::REG_UP_STEP:     up_step_r     <= cfg_wdata[dbslc_pkg::LevelW-1:0];
        dbslc_pkg::REG_DOWN_STEP:   down_step_r   <= cfg_wdata[dbslc_pkg::LevelW-1:0];
        dbslc_pkg::REG_UP_PERIOD:   up_period_r   <= cfg_wdata[dbslc_pkg::PeriodW-1:0];
        dbslc_pkg::REG_DOWN_PERIOD: down_period_r <= cfg_wdata[dbslc_pkg::PeriodW-1:0];
        dbslc_pkg::REG_MAX_LEVEL:   max_level_r   <= cfg_wdata[dbslc_pkg::LevelW-1:0];
        dbslc_pkg::REG_MIN_LEVEL:   min_level_r   <= cfg_wdata[dbslc_pkg::LevelW-1:0];
        dbslc_pkg::REG_TRIGGER:     trigger_r     <= cfg_wdata[dbslc_pkg::TrigW-1:0];
        default: ;
      endcase
    end
  end

  // Integrator: add deviation times current period, saturate to 40 bits
  always_comb begin
    cur_period = dbslc_pkg::eff_period(use_down_r ? down_period_r : up_period_r);
    prod       = $signed(s1_item_r.freq_dev) * $signed({1'b0, cur_period});
    sum        = $signed({integ_r[dbslc_pkg::IntegW-1], integ_r})
               + $signed({{(dbslc_pkg::IntegW-32){prod[32]}}, prod});
    if (sum[dbslc_pkg::IntegW] != sum[dbslc_pkg::IntegW-1]) begin
      sum_sat = sum[dbslc_pkg::IntegW] ? dbslc_pkg::IntegMin : dbslc_pkg::IntegMax;
    end else begin
      sum_sat = sum[dbslc_pkg::IntegW-1:0];
    end
    sat_ext  = $signed({sum_sat[dbslc_pkg::IntegW-1], sum_sat});
    trig_pos = $signed({2'b00, trigger_r});
    trig_neg = -trig_pos;
  end

  // Step decision: deadband first, then integrator against the trigger
  always_comb begin
    dev_ext  = $signed({s1_item_r.freq_dev[dbslc_pkg::DevW-1], s1_item_r.freq_dev});
    db_pos   = $signed({2'b00, deadband_r});
    db_neg   = -db_pos;
    dev_up   = dev_ext > db_pos;
    dev_down = dev_ext < db_neg;
    take_up   = dev_up || (!dev_down && (sat_ext > trig_pos));
    take_down = dev_down || (!dev_up && !(sat_ext > trig_pos) && (sat_ext < trig_neg));
    if (take_up) begin
      stepped = $signed({level_r[dbslc_pkg::LevelW-1], level_r})
              + $signed({up_step_r[dbslc_pkg::LevelW-1], up_step_r});
    end else if (take_down) begin
      stepped = $signed({level_r[dbslc_pkg::LevelW-1], level_r})
              + $signed({down_step_r[dbslc_pkg::LevelW-1], down_step_r});
    end else begin
      stepped = $signed({level_r[dbslc_pkg::LevelW-1], level_r});
    end
  end

  // Clamp to the bounds, swapped when min is above max
  always_comb begin
    if (min_level_r > max_level_r) begin
      lo = max_level_r;
      hi = min_level_r;
    end else begin
      lo = min_level_r;
      hi = max_level_r;
    end
    if (stepped > $signed({hi[dbslc_pkg::LevelW-1], hi})) begin
      clamped = hi;
    end else if (stepped < $signed({lo[dbslc_pkg::LevelW-1], lo})) begin
      clamped = lo;
    end else begin
      clamped = stepped[dbslc_pkg::LevelW-1:0];
    end
    new_period = dbslc_pkg::eff_period(dev_down ? down_period_r : up_period_r);
  end

  // Tick control: disable, rising enable, update or countdown
  always_comb begin
    level_nxt    = level_r;
    integ_nxt    = integ_r;
    ticks_nxt    = ticks_r;
    use_down_nxt = use_down_r;
    was_en_nxt   = was_en_r;
    updated_nxt  = 1'b0;
    if (!s1_item_r.enable) begin
      level_nxt  = '0;
      was_en_nxt = 1'b0;
    end else if (!was_en_r) begin
      ticks_nxt  = dbslc_pkg::eff_period(up_period_r);
      was_en_nxt = 1'b1;
    end else if (ticks_r <= dbslc_pkg::PeriodW'(1)) begin
      integ_nxt    = sum_sat;
      level_nxt    = clamped;
      use_down_nxt = dev_down;
      ticks_nxt    = new_period;
      updated_nxt  = 1'b1;
    end else begin
      ticks_nxt = ticks_r - dbslc_pkg::PeriodW'(1);
    end
  end

  // State and pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      integ_r     <= '0;
      ticks_r     <= '0;
      use_down_r  <= 1'b0;
      was_en_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        level_r    <= level_nxt;
        integ_r    <= integ_nxt;
        ticks_r    <= ticks_nxt;
        use_down_r <= use_down_nxt;
        was_en_r   <= was_en_nxt;
      end
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r.level   <= level_nxt;
      out_item_r.updated <= updated_nxt;
    end
  end

  // Countdown never sits at zero while the controller is running
  a_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    was_en_r |-> (ticks_r != '0))
    else $error("countdown is zero while enabled");

  // A disabled tick yields level zero and no update
  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_item_r.enable) |=>
      (out_valid && (out_data.level == '0) && !out_data.updated))
    else $error("disabled item gave a nonzero level or an update");

  // Input stalls only when stage 1 holds an item that cannot move on
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked item");

  // An update never happens on a tick right after a disabled one
  a_no_update_on_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !was_en_r) |-> !updated_nxt)
    else $error("update on the tick that raised enable");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for deadband_step_level_controller_unit.
// Predicts level and update flag per tick with its own controller model;
// depends only on dbslc_pkg and the unit under test.
module tb;
  import dbslc_pkg::*;

  localparam int StuckLimit = 2000;

  // Register set as the model holds it
  typedef struct {
    int     deadband;
    int     up_step;
    int     down_step;
    int     up_period;
    int     down_period;
    int     max_level;
    int     min_level;
    longint trigger;
  } ctl_settings_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // Controller model state and its register copy
  ctl_settings_t regs;
  int     lvl_now = 0;
  longint integ_acc = 0;
  int     ticks_left = 0;
  bit     down_pace = 1'b0;
  bit     running = 1'b0;

  out_item_t pending_levels[$];

  int  errors = 0;
  int  ticks_sent = 0;
  int  results_seen = 0;
  int  updates_predicted = 0;
  int  settings_loaded = 0;
  int  jam_left = 0;
  int  sink_wait = 0;
  int  stuck = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;

  deadband_step_level_controller_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Period register value as a tick count; zero counts as one
  function automatic int ticks_of(input int p);
    return (p == 0) ? 1 : p;
  endfunction

  // Advance the controller model by one tick and return the expected result
  function automatic out_item_t controller_tick(input int dev, input bit en);
    out_item_t r;
    int per;
    int lvl;
    int lo;
    int hi;
    longint acc;
    r.updated = 1'b0;
    if (!en) begin
      lvl_now = 0;
      running = 1'b0;
    end else if (!running) begin
      ticks_left = ticks_of(regs.up_period);
      running = 1'b1;
    end else if (ticks_left <= 1) begin
      per = ticks_of(down_pace ? regs.down_period : regs.up_period);
      acc = integ_acc + longint'(dev) * longint'(per);
      if (acc > longint'(IntegMax)) acc = longint'(IntegMax);
      if (acc < longint'(IntegMin)) acc = longint'(IntegMin);
      integ_acc = acc;
      lvl = lvl_now;
      if (dev > regs.deadband) begin
        lvl += regs.up_step;
        down_pace = 1'b0;
      end else if (dev < -regs.deadband) begin
        lvl += regs.down_step;
        down_pace = 1'b1;
      end else begin
        // inside the deadband only the integrator decides
        down_pace = 1'b0;
        if (acc > regs.trigger) lvl += regs.up_step;
        else if (acc < -regs.trigger) lvl += regs.down_step;
      end
      lo = regs.min_level;
      hi = regs.max_level;
      if (lo > hi) begin
        lo = regs.max_level;
        hi = regs.min_level;
      end
      if (lvl > hi) lvl = hi;
      if (lvl < lo) lvl = lo;
      lvl_now = lvl;
      ticks_left = ticks_of(down_pace ? regs.down_period : regs.up_period);
      r.updated = 1'b1;
      updates_predicted++;
    end else begin
      ticks_left--;
    end
    r.level = LevelW'(lvl_now);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  // Send one tick: optional idle gap, then hold until accepted
  task automatic send_tick(input int dev, input bit en);
    in_item_t it;
    int gap;
    it.freq_dev = DevW'(dev);
    it.enable = en;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_levels.push_back(controller_tick(int'(it.freq_dev), en));
    ticks_sent++;
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic await_idle();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t r, input longint v);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= CfgDataW'(v);
    @(posedge clk);
  endtask

  // Write the whole register set; only called with the unit idle
  task automatic load_settings(input ctl_settings_t s);
    put_reg(REG_DEADBAND, s.deadband);
    put_reg(REG_UP_STEP, s.up_step);
    put_reg(REG_DOWN_STEP, s.down_step);
    put_reg(REG_UP_PERIOD, s.up_period);
    put_reg(REG_DOWN_PERIOD, s.down_period);
    put_reg(REG_MAX_LEVEL, s.max_level);
    put_reg(REG_MIN_LEVEL, s.min_level);
    put_reg(REG_TRIGGER, s.trigger);
    cfg_we <= 1'b0;
    regs = s;
    settings_loaded++;
  endtask

  function automatic int rand_s16();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int rand_period();
    case ($urandom_range(0, 19))
      0, 1:    return 0;
      2:       return $urandom_range(100, 65535);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  function automatic int rand_step();
    if ($urandom_range(0, 1)) return rand_s16();
    return int'($urandom_range(0, 600)) - 300;
  endfunction

  function automatic ctl_settings_t random_settings();
    ctl_settings_t s;
    int a;
    int b;
    case ($urandom_range(0, 3))
      0:       s.deadband = 0;
      1:       s.deadband = 32767;
      2:       s.deadband = $urandom_range(0, 300);
      default: s.deadband = $urandom_range(0, 32767);
    endcase
    s.up_step = rand_step();
    s.down_step = rand_step();
    s.up_period = rand_period();
    s.down_period = rand_period();
    a = rand_s16();
    b = rand_s16();
    // bounds mostly swapped, sometimes in order
    if (($urandom_range(0, 3) == 0) == (a > b)) begin
      s.max_level = a;
      s.min_level = b;
    end else begin
      s.max_level = b;
      s.min_level = a;
    end
    s.trigger = ({32'($urandom), 32'($urandom)} & 64'h7F_FFFF_FFFF)
                >> $urandom_range(12, 38);
    return s;
  endfunction

  // Deviation: random, near the edges of the current deadband, inside it, or at an extreme
  function automatic int rand_dev();
    int d;
    int band;
    band = regs.deadband;
    case ($urandom_range(0, 4))
      0:       d = rand_s16();
      1:       d = band + int'($urandom_range(0, 4)) - 2;
      2:       d = -band + int'($urandom_range(0, 4)) - 2;
      3:       d = int'($urandom_range(0, 2 * band)) - band;
      default: d = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    if (d > 32767) d = 32767;
    if (d < -32768) d = -32768;
    return d;
  endfunction

  // Mostly enabled ticks with short disabled bursts
  task automatic run_random_ticks(input int n);
    int off_left;
    bit en;
    off_left = 0;
    repeat (n) begin
      if (off_left > 0) begin
        off_left--;
        en = 1'b0;
      end else if ($urandom_range(0, 29) == 0) begin
        off_left = $urandom_range(0, 3);
        en = 1'b0;
      end else begin
        en = 1'b1;
      end
      send_tick(rand_dev(), en);
    end
  endtask

  // Reset values, disabled tick and enable rise with zero steps
  task automatic test_reset_defaults();
    send_tick(0, 1'b0);
    send_tick(32767, 1'b1);
    send_tick(-32768, 1'b1);
    send_tick(0, 1'b1);
  endtask

  // Full-size steps, clamp at both ends, deadband edges, disable
  task automatic test_step_and_clamp();
    await_idle();
    load_settings('{100, 32767, -32768, 1, 1, 32767, -32768, 0});
    send_tick(0, 1'b0);
    send_tick(0, 1'b1);
    send_tick(32767, 1'b1);
    send_tick(32767, 1'b1);
    send_tick(-32768, 1'b1);
    send_tick(-32768, 1'b1);
    send_tick(100, 1'b1);
    send_tick(-100, 1'b1);
    send_tick(101, 1'b1);
    send_tick(-101, 1'b1);
    send_tick(0, 1'b0);
    send_tick(12345, 1'b0);
  endtask

  // Zero periods count as one tick; reversed bounds still clamp
  task automatic test_zero_period_and_swapped_bounds();
    await_idle();
    load_settings('{0, 500, -500, 0, 0, -100, 100, 5});
    send_tick(0, 1'b1);
    send_tick(1, 1'b1);
    send_tick(-1, 1'b1);
    send_tick(-1, 1'b1);
    send_tick(0, 1'b1);
    send_tick(3, 1'b1);
  endtask

  // Every register at its top and at its bottom
  task automatic test_register_extremes();
    await_idle();
    load_settings('{32767, 32767, 32767, 65535, 65535, 32767, 32767,
                    longint'(IntegMax)});
    run_random_ticks(25);
    await_idle();
    load_settings('{0, -32768, -32768, 1, 1, -32768, -32768, 0});
    run_random_ticks(25);
    await_idle();
    load_settings('{0, 32767, -32768, 1, 1, -32768, 32767, 0});
    run_random_ticks(25);
  endtask

  // Random register sets, idling on or off per phase
  task automatic test_random_settings();
    repeat (9) begin
      await_idle();
      load_settings(random_settings());
      tx_idle = $urandom_range(0, 2) != 0;
      rx_idle = $urandom_range(0, 2) != 0;
      run_random_ticks(60);
    end
  endtask

  // Receiver holds off long while ticks keep coming, so the input stalls
  task automatic test_input_backpressure();
    await_idle();
    load_settings(random_settings());
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    jam_left = 150;
    run_random_ticks(40);
  endtask

  // Drive the integrator into its negative limit, then probe it through
  // the trigger comparison at the widest trigger
  task automatic test_integrator_saturation();
    await_idle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    load_settings('{0, 0, -1, 1, 65535, 32767, -32768, 0});
    // re-enabling reloads the countdown with the short up period, while
    // the product keeps using the long down period
    repeat (270) begin
      send_tick(0, 1'b0);
      send_tick(0, 1'b1);
      send_tick(-32768, 1'b1);
    end
    await_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_settings('{32767, 1, -1, 1, 1, 32767, -32768, longint'(IntegMax)});
    send_tick(0, 1'b0);
    send_tick(0, 1'b1);
    send_tick(0, 1'b1);
    send_tick(0, 1'b1);
    send_tick(1, 1'b1);
    send_tick(0, 1'b1);
    send_tick(-1, 1'b1);
    send_tick(-32768, 1'b1);
  endtask

  // Result side pacing: a random hold-off per result, plus a long jam
  always @(posedge clk) begin : sink_pacing
    if (out_valid === 1'b1 && out_stall === 1'b0)
      sink_wait = rx_idle ? $urandom_range(0, 19) : 0;
    if (jam_left > 0) begin
      jam_left--;
      out_stall <= 1'b1;
    end else if (sink_wait > 0) begin
      sink_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_levels.size() == 0) begin
        report_mismatch("result with nothing pending, level", longint'(out_data.level), 0);
      end else begin
        want = pending_levels.pop_front();
        if (out_data.level !== want.level)
          report_mismatch("level", longint'(out_data.level), longint'(want.level));
        if (out_data.updated !== want.updated)
          report_mismatch("updated", longint'(out_data.updated), longint'(want.updated));
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk) begin : watchdog
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0))
      stuck = 0;
    else
      stuck++;
    if (stuck >= StuckLimit) begin
      $display("timeout: no item moved for %0d cycles, %0d still pending",
               stuck, pending_levels.size());
      $display("deadband_step_level_controller_unit regression: fail");
      $finish;
    end
  end

  initial begin : regression
    regs = '{0, 0, 0, int'(PeriodRst), int'(PeriodRst), int'(MaxLevelRst),
             int'(MinLevelRst), 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_step_and_clamp();
    test_zero_period_and_swapped_bounds();
    test_register_extremes();
    test_random_settings();
    test_input_backpressure();
    test_integrator_saturation();
    await_idle();
    repeat (8) @(posedge clk);
    $display("%0d ticks sent, %0d results checked, %0d updates, %0d register sets",
             ticks_sent, results_seen, updates_predicted, settings_loaded);
    $display("covered clamp, deadband edges, zero periods, back-pressure, saturation");
    if (errors == 0) begin
      $display("deadband_step_level_controller_unit regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("deadband_step_level_controller_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dbslc_pkg.sv
rtl/deadband_step_level_controller_unit.sv
test/tb.sv
